// ===== hdl/ite_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_pkg
// shared types and constants for the tilt estimator
// ----------------------------------------------------------------------------
package ite_pkg;

  localparam int unsigned TABLE_FRAC = 24;
  localparam int unsigned PRESCALE   = 20;

  // register indexes
  localparam logic [2:0] REG_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_PERIOD     = 3'd1;
  localparam logic [2:0] REG_WEIGHT     = 3'd2;
  localparam logic [2:0] REG_LIMIT      = 3'd3;
  localparam logic [2:0] REG_FAULT      = 3'd4;

  // accelerometer pitch class
  localparam logic [1:0] ACC_CORDIC = 2'd0;
  localparam logic [1:0] ACC_ZERO   = 2'd1;
  localparam logic [1:0] ACC_POS90  = 2'd2;
  localparam logic [1:0] ACC_NEG90  = 2'd3;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [1:0]         acc_class;
  } item_t;

  typedef struct packed {
    logic [10:0] gyro_full_scale;
    logic [23:0] sample_period_q24;
    logic [15:0] fuse_weight_q16;
    logic [6:0]  tilt_limit_deg;
    logic [11:0] fault_ticks;
  } cfg_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0: r = 32'sd754974720;  5'd1: r = 32'sd445687602;
        5'd2: r = 32'sd235489088;  5'd3: r = 32'sd119537938;
        5'd4: r = 32'sd60000934;   5'd5: r = 32'sd30029717;
        5'd6: r = 32'sd15018523;   5'd7: r = 32'sd7509720;
        5'd8: r = 32'sd3754917;    5'd9: r = 32'sd1877466;
        5'd10: r = 32'sd938734;    5'd11: r = 32'sd469367;
        5'd12: r = 32'sd234684;    5'd13: r = 32'sd117342;
        5'd14: r = 32'sd58671;     5'd15: r = 32'sd29335;
        5'd16: r = 32'sd14668;     5'd17: r = 32'sd7334;
        5'd18: r = 32'sd3667;      5'd19: r = 32'sd1833;
        5'd20: r = 32'sd917;       5'd21: r = 32'sd458;
        5'd22: r = 32'sd229;       5'd23: r = 32'sd115;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ite_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_if
// valid/ready channel interfaces for samples, results and configuration
// ----------------------------------------------------------------------------
interface ite_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_z;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  modport source (output valid, acc_x, acc_z, gyro_y, gyro_z, input ready);
  modport sink   (input valid, acc_x, acc_z, gyro_y, gyro_z, output ready);
endinterface

interface ite_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  logic tilt_fault;
  modport source (output valid, pitch_angle, yaw_angle, tilt_fault, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, tilt_fault, output ready);
endinterface

interface ite_cfg_if;
  logic valid;
  logic ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/imu_tilt_estimator_with_fault.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_estimator_with_fault
// pitch/yaw estimator with complementary blend and over-tilt fault latch
// ----------------------------------------------------------------------------
// each item is one imu sample and gives one result item. the back end's
// sequencer steps one item at a time through S_IDLE, S_MUL1, S_MUL2, S_CORD
// (vectoring cordic, one iteration per cycle), S_BLND, S_SUM, S_FLT, S_OUT.
// a two-entry queue lets the front take samples while the back works and a
// result register holds the last result until it is taken. config writes
// are taken at any time but must only be made while the block is idle.
module imu_tilt_estimator_with_fault #(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  ite_in_if.sink     in_ch,
  ite_out_if.source  out_ch,
  ite_cfg_if.sink    cfg_ch
);
  ite_pkg::cfg_t  cfg;
  ite_pkg::item_t q_item;
  logic q_valid, q_pop;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_full_scale   <= 11'd2000;
      cfg.sample_period_q24 <= 24'd16777;
      cfg.fuse_weight_q16   <= 16'd66;
      cfg.tilt_limit_deg    <= 7'd30;
      cfg.fault_ticks       <= 12'd200;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ite_pkg::REG_FULL_SCALE: cfg.gyro_full_scale   <= cfg_ch.data[10:0];
        ite_pkg::REG_PERIOD:     cfg.sample_period_q24 <= cfg_ch.data[23:0];
        ite_pkg::REG_WEIGHT:     cfg.fuse_weight_q16   <= cfg_ch.data[15:0];
        ite_pkg::REG_LIMIT:      cfg.tilt_limit_deg    <= cfg_ch.data[6:0];
        ite_pkg::REG_FAULT:      cfg.fault_ticks       <= cfg_ch.data[11:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  ite_front u_front (
    .clk, .rst, .in_ch,
    .q_item, .q_valid, .q_pop
  );

  // back: sequencer doing the arithmetic
  ite_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk, .rst, .cfg, .q_item, .q_valid, .q_pop, .out_ch
  );
endmodule
`default_nettype wire

// ===== hdl/ite_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_front
// accepts samples, classifies the accelerometer case, two-entry queue
// ----------------------------------------------------------------------------
module ite_front (
  input  wire  logic          clk,
  input  wire  logic          rst,
  ite_in_if.sink              in_ch,
  output ite_pkg::item_t      q_item,
  output logic                q_valid,
  input  wire  logic          q_pop
);
  ite_pkg::item_t mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  ite_pkg::item_t cls;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];

  always_comb begin
    cls.acc_x = in_ch.acc_x;
    cls.acc_z = in_ch.acc_z;
    cls.gyro_y = in_ch.gyro_y;
    cls.gyro_z = in_ch.gyro_z;
    if (in_ch.acc_x == 16'sd0) begin
      cls.acc_class = ite_pkg::ACC_ZERO;
    end else if (in_ch.acc_z == 16'sd0) begin
      cls.acc_class = in_ch.acc_x[15] ? ite_pkg::ACC_POS90 : ite_pkg::ACC_NEG90;
    end else begin
      cls.acc_class = ite_pkg::ACC_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ite_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_back
// rate integration, cordic, blend and fault logic, one item at a time
// ----------------------------------------------------------------------------
module ite_back #(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  wire  logic         clk,
  input  wire  logic         rst,
  input  ite_pkg::cfg_t      cfg,
  input  ite_pkg::item_t     q_item,
  input  wire  logic         q_valid,
  output logic               q_pop,
  ite_out_if.source          out_ch
);
  localparam int unsigned RSH = 39 - ANGLE_FRAC_BITS;
  localparam int unsigned ZSH = ite_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_CORD  = 3'd3;
  localparam logic [2:0] S_BLND  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_FLT   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  ite_pkg::item_t it;
  logic [34:0] fsp;                 // full scale * period
  logic signed [51:0] pz, py;       // rate products
  logic signed [39:0] cx, cy;
  logic signed [31:0] cz;
  logic [4:0] step;
  logic signed [63:0] gyro_pitch;
  logic signed [31:0] acc_p;
  logic signed [63:0] bl_a, bl_g;
  logic [31:0] pitch_store, yaw_store;
  logic [11:0] over_cnt;
  logic fault;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic signed [63:0] r;
    begin
      if (s == 0) r = v;
      else r = (v + (64'sd1 <<< (s - 1))) >>> s;
      return r;
    end
  endfunction

  logic signed [16:0] gz_eff;
  assign gz_eff = (it.gyro_z >= -16'sd2 && it.gyro_z <= 16'sd2) ? 17'sd0
                  : 17'(it.gyro_z);

  logic signed [39:0] sx, sy;
  assign sx = cx >>> step;
  assign sy = cy >>> step;

  logic signed [31:0] lim;
  logic signed [31:0] pnow;
  assign lim = 32'(cfg.tilt_limit_deg) <<< ANGLE_FRAC_BITS;
  assign pnow = pitch_store;

  logic [11:0] cnt_upd;
  always_comb begin
    if (pnow > lim || pnow < -lim) begin
      cnt_upd = (over_cnt == 12'hFFF) ? over_cnt : over_cnt + 12'd1;
    end else if (over_cnt >= 12'd5) begin
      cnt_upd = over_cnt - 12'd5;
    end else begin
      cnt_upd = 12'd0;
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pitch_store <= '0;
      yaw_store <= '0;
      over_cnt <= '0;
      fault <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // result register drains here except when a new result is loaded
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          fsp <= 35'(cfg.gyro_full_scale) * 35'(cfg.sample_period_q24);
          cz <= '0;
          step <= '0;
          if (it.acc_z[15]) begin
            cx <= -(40'(it.acc_z) <<< ite_pkg::PRESCALE);
            cy <= -(40'(it.acc_x) <<< ite_pkg::PRESCALE);
          end else begin
            cx <= 40'(it.acc_z) <<< ite_pkg::PRESCALE;
            cy <= 40'(it.acc_x) <<< ite_pkg::PRESCALE;
          end
          state <= S_MUL2;
        end
        S_MUL2: begin
          pz <= 52'(gz_eff) * $signed({17'd0, fsp});
          py <= 52'(it.gyro_y) * $signed({17'd0, fsp});
          state <= S_CORD;
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + ite_pkg::atan_deg(step);
          end else begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - ite_pkg::atan_deg(step);
          end
          if (32'(step) + 32'd1 >= NSTEP) state <= S_BLND;
          step <= step + 5'd1;
        end
        S_BLND: begin
          yaw_store <= yaw_store + 32'(rnd(64'(pz), RSH));
          gyro_pitch <= 64'($signed(pitch_store)) + rnd(64'(py), RSH);
          unique case (it.acc_class)
            ite_pkg::ACC_ZERO:  acc_p <= '0;
            ite_pkg::ACC_POS90: acc_p <= 32'sd90 <<< ANGLE_FRAC_BITS;
            ite_pkg::ACC_NEG90: acc_p <= -(32'sd90 <<< ANGLE_FRAC_BITS);
            default:            acc_p <= -32'(rnd(64'(cz), ZSH));
          endcase
          state <= S_SUM;
        end
        S_SUM: begin
          bl_a <= 64'($signed({1'b0, cfg.fuse_weight_q16})) * 64'(acc_p);
          bl_g <= (64'sd65536 - 64'($signed({1'b0, cfg.fuse_weight_q16})))
                  * gyro_pitch;
          state <= S_FLT;
        end
        S_FLT: begin
          pitch_store <= 32'(rnd(bl_a + bl_g, 16));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (!fault) begin
              if (cnt_upd >= cfg.fault_ticks) begin
                fault <= 1'b1;
                over_cnt <= '0;
                out_ch.tilt_fault <= 1'b1;
              end else begin
                over_cnt <= cnt_upd;
                out_ch.tilt_fault <= 1'b0;
              end
            end else begin
              out_ch.tilt_fault <= 1'b1;
            end
            out_ch.pitch_angle <= pitch_store;
            out_ch.yaw_angle <= yaw_store;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ite_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ite_checker
// port-level checks for the tilt estimator
// ----------------------------------------------------------------------------
module ite_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic tilt_fault,
  input wire logic in_valid,
  input wire logic in_ready
);
  // fault never clears once shown
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && tilt_fault) |=> (!out_valid || tilt_fault))
    else $error("fault cleared");
  // output stays while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped");
  // no result right after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output after reset");
  // an offered item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> in_valid)
    else $error("input dropped");
endmodule

bind imu_tilt_estimator_with_fault ite_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .tilt_fault(out_ch.tilt_fault),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready)
);
`default_nettype wire

// ===== sim/imu_tilt_estimator_with_fault_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_estimator_with_fault_test
// self-checking bench: directed table, fault trip, then random samples, every
// result item compared field by field with a typed-in row or in-bench predictor
// ----------------------------------------------------------------------------
module imu_tilt_estimator_with_fault_test;

  localparam int FRAC  = 16;
  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic               fault;
  } estimate_t;

  // one row of the directed table; check_fixed marks rows whose result is typed in
  typedef struct {
    logic signed [15:0] ax, az, gy, gz;
    bit        check_fixed;
    estimate_t fixed;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ite_in_if  in_ch ();
  ite_out_if out_ch ();
  ite_cfg_if cfg_ch ();

  imu_tilt_estimator_with_fault uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers and state
  logic [10:0] full_scale;
  logic [23:0] period_q24;
  logic [15:0] weight_q16;
  logic [6:0]  limit_deg;
  logic [11:0] fault_count_limit;
  logic [31:0] pitch_acc;
  logic [31:0] yaw_acc;
  logic [11:0] tilt_count;
  logic        fault_flag;

  estimate_t expected_estimates[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_up_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint scaled_rate(longint rate);
    longint p;
    p = rate * longint'(full_scale) * longint'(period_q24);
    return round_up_shift(p, 39 - FRAC);
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                        30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                        469367, 234684, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115};
    return tab[i];
  endfunction

  // -atan(ax/az) in degrees, vectoring cordic
  function automatic longint tilt_from_accel(longint ax, longint az);
    longint x, y, xo, z;
    z = 0;
    if (az == 0) begin
      if (ax == 0) return 0;
      return (ax > 0) ? -(longint'(90) << FRAC) : (longint'(90) << FRAC);
    end
    if (ax == 0) return 0;
    x = (az < 0 ? -az : az) <<< ite_pkg::PRESCALE;
    y = (az < 0 ? -ax : ax) <<< ite_pkg::PRESCALE;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + floor_shift(y, i);
        y = y - floor_shift(xo, i);
        z += atan_entry(i);
      end else begin
        x = x - floor_shift(y, i);
        y = y + floor_shift(xo, i);
        z -= atan_entry(i);
      end
    end
    return -round_up_shift(z, ite_pkg::TABLE_FRAC - FRAC);
  endfunction

  function automatic estimate_t estimate_sample(logic signed [15:0] ax,
      logic signed [15:0] az, logic signed [15:0] gy, logic signed [15:0] gz);
    longint yaw_rate, gyro_pitch, acc_pitch, blend, lim, p;
    estimate_t e;
    yaw_rate = (gz >= -2 && gz <= 2) ? 0 : longint'(gz);
    yaw_acc = yaw_acc + 32'(scaled_rate(yaw_rate));
    gyro_pitch = longint'($signed(pitch_acc)) + scaled_rate(longint'(gy));
    acc_pitch = tilt_from_accel(longint'(ax), longint'(az));
    blend = longint'(weight_q16) * acc_pitch
          + (65536 - longint'(weight_q16)) * gyro_pitch;
    pitch_acc = 32'(round_up_shift(blend, 16));
    if (!fault_flag) begin
      p = longint'($signed(pitch_acc));
      lim = longint'(limit_deg) << FRAC;
      if (p > lim || p < -lim) begin
        if (tilt_count != 12'hFFF) tilt_count++;
      end else if (tilt_count >= 5) begin
        tilt_count -= 5;
      end else begin
        tilt_count = 0;
      end
      if (tilt_count >= fault_count_limit) begin
        fault_flag = 1'b1;
        tilt_count = 0;
      end
    end
    e.pitch = pitch_acc;
    e.yaw = yaw_acc;
    e.fault = fault_flag;
    return e;
  endfunction

  task automatic apply_register(logic [2:0] idx, logic [31:0] value);
    case (idx)
      ite_pkg::REG_FULL_SCALE: full_scale = value[10:0];
      ite_pkg::REG_PERIOD:     period_q24 = value[23:0];
      ite_pkg::REG_WEIGHT:     weight_q16 = value[15:0];
      ite_pkg::REG_LIMIT:      limit_deg = value[6:0];
      ite_pkg::REG_FAULT:      fault_count_limit = value[11:0];
      default: ;
    endcase
  endtask

  // drive one config write and wait for its handshake
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_register(idx, value);
  endtask

  // wait for every expected item, then let the back end settle
  task automatic wait_idle();
    while (expected_estimates.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send one sample with random gaps before it
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
      logic signed [15:0] gy, logic signed [15:0] gz, bit check_fixed,
      estimate_t fixed);
    estimate_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.acc_x <= ax;
    in_ch.acc_z <= az;
    in_ch.gyro_y <= gy;
    in_ch.gyro_z <= gz;
    do @(posedge clk); while (!in_ch.ready);
    e = estimate_sample(ax, az, gy, gz);
    if (check_fixed && e !== fixed)
      $display("table row disagrees with predictor: row %h pred %h", fixed, e);
    expected_estimates.push_back(check_fixed ? fixed : e);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  // random sample: mostly near-level attitudes, sometimes full-range noise or near-zero az
  task automatic send_random();
    logic signed [15:0] ax, az, gy, gz;
    estimate_t none;
    none = '0;
    case ($urandom_range(9))
      0, 1: begin
        ax = 16'($urandom); az = 16'($urandom);
        gy = 16'($urandom); gz = 16'($urandom);
      end
      2: begin
        ax = 16'($urandom_range(8000)) - 16'sd4000; az = 16'($urandom_range(1)) ? 0 : 1;
        gy = 16'($urandom_range(6)) - 16'sd3; gz = 16'($urandom_range(6)) - 16'sd3;
      end
      default: begin
        ax = 16'($urandom_range(16000)) - 16'sd8000;
        az = 16'($urandom_range(8000)) + 16'sd12000;
        if ($urandom_range(3) == 0) az = -az;
        gy = 16'($urandom_range(4000)) - 16'sd2000;
        gz = 16'($urandom_range(2000)) - 16'sd1000;
      end
    endcase
    send_sample(ax, az, gy, gz, 1'b0, none);
  endtask

  // receiver: random stalls, checks each accepted result item
  always @(posedge clk) begin
    estimate_t got, exp_e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pitch = out_ch.pitch_angle;
        got.yaw = out_ch.yaw_angle;
        got.fault = out_ch.tilt_fault;
        if (expected_estimates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result item: pitch %h yaw %h fault %b",
                     got.pitch, got.yaw, got.fault);
        end else begin
          exp_e = expected_estimates.pop_front();
          if (got.pitch !== exp_e.pitch || got.yaw !== exp_e.yaw ||
              got.fault !== exp_e.fault) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: pitch exp %h got %h, yaw exp %h got %h, fault exp %b got %b",
                       exp_e.pitch, got.pitch, exp_e.yaw, got.yaw,
                       exp_e.fault, got.fault);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    sample_row_t rows[$];
    sample_row_t r;
    estimate_t zero_e;
    int phase;

    in_ch.valid = 1'b0;
    in_ch.acc_x = '0;
    in_ch.acc_z = '0;
    in_ch.gyro_y = '0;
    in_ch.gyro_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;

    // reset values
    full_scale = 11'd2000;
    period_q24 = 24'd16777;
    weight_q16 = 16'd66;
    limit_deg = 7'd30;
    fault_count_limit = 12'd200;
    pitch_acc = '0;
    yaw_acc = '0;
    tilt_count = '0;
    fault_flag = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: all-zero sample after reset gives all-zero result,
    // the rest covers extremes and the accelerometer special cases
    zero_e = '0;
    r = '{0, 0, 0, 0, 1'b1, zero_e};                   rows.push_back(r);
    r = '{0, 0, 0, 2, 1'b1, zero_e};                   rows.push_back(r); // dead band
    r = '{0, 0, 0, -2, 1'b1, zero_e};                  rows.push_back(r);
    r = '{0, 100, 0, 0, 1'b1, zero_e};                 rows.push_back(r); // ax zero
    r = '{0, -32768, 0, 0, 1'b1, zero_e};              rows.push_back(r);
    r = '{1000, 0, 0, 0, 1'b0, zero_e};                rows.push_back(r); // az zero
    r = '{-1000, 0, 0, 0, 1'b0, zero_e};               rows.push_back(r);
    r = '{32767, 32767, 0, 3, 1'b0, zero_e};           rows.push_back(r);
    r = '{-32768, -32768, 0, -3, 1'b0, zero_e};        rows.push_back(r);
    r = '{-32768, 32767, 32767, 32767, 1'b0, zero_e};  rows.push_back(r);
    r = '{32767, -32768, -32768, -32768, 1'b0, zero_e}; rows.push_back(r);
    r = '{16'h5555, 16'h2AAA, 16'h5555, 16'hAAAA, 1'b0, zero_e}; rows.push_back(r);
    r = '{16'hAAAA, 16'hD555, 16'hAAAA, 16'h5555, 1'b0, zero_e}; rows.push_back(r);
    foreach (rows[i])
      send_sample(rows[i].ax, rows[i].az, rows[i].gy, rows[i].gz,
                  rows[i].check_fixed, rows[i].fixed);
    end_burst();
    wait_idle();

    // full weight on the accelerometer, low limit, short fault count: trips fault
    write_register(ite_pkg::REG_WEIGHT, 32'd65535);
    write_register(ite_pkg::REG_LIMIT, 32'd1);
    write_register(ite_pkg::REG_FAULT, 32'd3);
    write_register(3'd7, 32'hFFFF_FFFF); // unused index, ignored
    for (int i = 0; i < 8; i++)
      send_sample(16'sd20000, 16'sd1000, 0, 16'sd500, 1'b0, zero_e);
    end_burst();
    wait_idle();

    // random phases: each runs through its own register setting and idling mix
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (phase)
        0: begin
          write_register(ite_pkg::REG_FULL_SCALE, 32'd250);
          write_register(ite_pkg::REG_PERIOD, 32'd16777);
          write_register(ite_pkg::REG_WEIGHT, 32'd66);
          write_register(ite_pkg::REG_LIMIT, 32'd30);
          write_register(ite_pkg::REG_FAULT, 32'd4095);
        end
        1: begin
          write_register(ite_pkg::REG_FULL_SCALE, 32'd2047);
          write_register(ite_pkg::REG_PERIOD, 32'hFF_FFFF);
          write_register(ite_pkg::REG_WEIGHT, 32'd0);
          write_register(ite_pkg::REG_LIMIT, 32'd127);
        end
        2: begin
          write_register(ite_pkg::REG_FULL_SCALE, 32'd0);
          write_register(ite_pkg::REG_PERIOD, 32'd1);
          write_register(ite_pkg::REG_WEIGHT, 32'd32768);
          write_register(ite_pkg::REG_LIMIT, 32'd5);
          write_register(ite_pkg::REG_FAULT, 32'd0);
        end
        3: begin
          write_register(ite_pkg::REG_FULL_SCALE, 32'd1000);
          write_register(ite_pkg::REG_PERIOD, 32'd0);
          write_register(ite_pkg::REG_WEIGHT, 32'd65535);
          write_register(ite_pkg::REG_LIMIT, 32'd90);
          write_register(ite_pkg::REG_FAULT, 32'd1);
        end
        default: begin
          write_register(ite_pkg::REG_FULL_SCALE, 32'($urandom_range(2047)));
          write_register(ite_pkg::REG_PERIOD, 32'($urandom_range(24'hFF_FFFF)));
          write_register(ite_pkg::REG_WEIGHT, 32'($urandom_range(16'hFFFF)));
          write_register(ite_pkg::REG_LIMIT, 32'($urandom_range(127)));
          write_register(ite_pkg::REG_FAULT, 32'($urandom_range(300)));
        end
      endcase
      for (int i = 0; i < 240; i++) begin
        send_random();
        // hold off once, midway through the first phase, until the pipe is empty
        if (i == 120 && phase == 0) begin
          end_burst();
          while (expected_estimates.size() != 0) @(posedge clk);
        end
      end
      end_burst();
      wait_idle();
    end

    if (mismatch_count == 0 && expected_estimates.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== imu_tilt_estimator_with_fault.f =====
hdl/ite_pkg.sv
hdl/ite_if.sv
hdl/ite_front.sv
hdl/ite_back.sv
hdl/imu_tilt_estimator_with_fault.sv
hdl/ite_checker.sv
sim/imu_tilt_estimator_with_fault_test.sv
